>>> rtl/scps_pkg.sv
// ----------------------------------------------------------------------------
// scps_pkg
// Shared widths, request codes, register indexes, state type and memory
// request structs for the split candidate predictor sampler.
// ----------------------------------------------------------------------------
package scps_pkg;

   localparam int unsigned MAX_PRED_DEF   = 64;
   localparam int unsigned UNIFORM_BITS   = 16;
   localparam int unsigned PROB_FRAC_BITS = 16;

   localparam int unsigned PRED_W = 6;
   localparam int unsigned NODE_W = 16;
   localparam int unsigned UNI_W  = 16;
   localparam int unsigned PROB_W = 17;
   localparam int unsigned CFG_W  = 7;
   localparam int unsigned REQ_W  = 2;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CMP_W  = PROB_W + UNIFORM_BITS;

   localparam logic [UNI_W-1:0] UNI_MASK = UNI_W'((64'd1 << UNIFORM_BITS) - 64'd1);

   localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_UNIFORM = 2'd1;
   localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRED_COUNT  = 1'b1;

   localparam logic [CFG_W-1:0] FIXED_COUNT_RST = 7'd0;
   localparam logic [CFG_W-1:0] PRED_COUNT_RST  = 7'd64;

   typedef enum logic {
      ST_IDLE,
      ST_STEP
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [PRED_W-1:0] rd_addr_a;
      logic [PRED_W-1:0] rd_addr_b;
      logic              wr_en;
      logic [PRED_W-1:0] wr_addr;
      logic [PRED_W-1:0] wr_data;
   } perm_req_type;

   typedef struct packed {
      logic              rd_en;
      logic [PRED_W-1:0] rd_addr;
      logic              wr_en;
      logic [PRED_W-1:0] wr_addr;
      logic [PROB_W-1:0] wr_data;
   } prob_req_type;

endpackage

>>> rtl/scps_perm_mem.sv
// ----------------------------------------------------------------------------
// scps_perm_mem
// Permutation store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module scps_perm_mem #(
   parameter int unsigned DEPTH = scps_pkg::MAX_PRED_DEF
) (
   input  logic                        clock,
   input  scps_pkg::perm_req_type      req,
   output logic [scps_pkg::PRED_W-1:0] rd_data_a,
   output logic [scps_pkg::PRED_W-1:0] rd_data_b
);
   import scps_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [PRED_W-1:0] mem [DEPTH];
   logic [PRED_W-1:0] rd_a_ff;
   logic [PRED_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr[AW-1:0]] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_a_ff <= mem[req.rd_addr_a[AW-1:0]];
         rd_b_ff <= mem[req.rd_addr_b[AW-1:0]];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> rtl/scps_prob_mem.sv
// ----------------------------------------------------------------------------
// scps_prob_mem
// Probability store with per-entry valid flags; an entry not loaded since
// reset reads as zero.
// ----------------------------------------------------------------------------
module scps_prob_mem #(
   parameter int unsigned DEPTH = scps_pkg::MAX_PRED_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  scps_pkg::prob_req_type      req,
   output logic [scps_pkg::PROB_W-1:0] rd_data
);
   import scps_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [PROB_W-1:0] mem [DEPTH];
   logic [PROB_W-1:0] data_ff;
   logic [DEPTH-1:0]  vld_ff;
   logic              hit_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr[AW-1:0]] <= req.wr_data;
      end
      if (req.rd_en) begin
         data_ff <= mem[req.rd_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            vld_ff[req.wr_addr[AW-1:0]] <= 1'b1;
         end
         if (req.rd_en) begin
            hit_ff <= vld_ff[req.rd_addr[AW-1:0]];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

>>> rtl/split_candidate_predictor_sampler.sv
// A candidate from a uniform transaction passes the step state, then drives the rsp_
// ports for one cycle, marked by rsp_valid; the receiver cannot stall. Busy is high
// only in the step state of a launched uniform transaction, which blocks new ones and
// writes back the permutation or advances the walk; start, load and drops skip it.
// Reset: synchronous, active high; clears control, counters and the probability valid
// flags, sets the configuration defaults; memory contents and datapath registers stay.
// ----------------------------------------------------------------------------
// split_candidate_predictor_sampler
// Picks candidate predictors per tree node by a partial Fisher-Yates draw
// over a permutation memory, or by a per-predictor probability walk.
// ----------------------------------------------------------------------------
module split_candidate_predictor_sampler #(
   parameter int unsigned MAX_PRED = scps_pkg::MAX_PRED_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [scps_pkg::REQ_W-1:0]     req_type,
   input  logic [scps_pkg::NODE_W-1:0]    req_node_index,
   input  logic                           req_unsplitable,
   input  logic [MAX_PRED-1:0]            req_eligible_mask,
   input  logic [scps_pkg::UNI_W-1:0]     req_uniform,
   input  logic [scps_pkg::PRED_W-1:0]    req_prob_index,
   input  logic [scps_pkg::PROB_W-1:0]    req_prob_value,
   output logic                           rsp_valid,
   output logic [scps_pkg::NODE_W-1:0]    rsp_out_node,
   output logic [scps_pkg::PRED_W-1:0]    rsp_predictor,
   output logic [scps_pkg::UNI_W-1:0]     rsp_out_uniform,
   output logic                           rsp_selected,
   output logic                           rsp_scheduled,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [scps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [scps_pkg::CFG_W-1:0]     csr_wdata
);
   import scps_pkg::*;

   localparam int unsigned PW = (MAX_PRED > 1) ? $clog2(MAX_PRED) : 1;
   localparam int unsigned CW = $clog2(MAX_PRED + 1);
   localparam int unsigned MW = CW + UNI_W;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  fixed_count_ff, fixed_count_in;
   logic [CFG_W-1:0]  pred_count_ff, pred_count_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [MAX_PRED-1:0] mask_ff, mask_in;
   logic [MAX_PRED-1:0] written_ff, written_in;
   logic              active_ff, active_in;
   logic [CW-1:0]     size_ff, size_in;
   logic [CW-1:0]     remaining_ff, remaining_in;
   logic [CFG_W-1:0]  accepted_ff, accepted_in;
   logic [CW-1:0]     visit_ff, visit_in;
   logic              fixed_step_ff, fixed_step_in;
   logic [PW-1:0]     idx_ff, idx_in;
   logic [PW-1:0]     top_ff, top_in;
   logic [UNI_W-1:0]  uni_ff, uni_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic [PRED_W-1:0] rsp_pred_ff, rsp_pred_in;
   logic [UNI_W-1:0]  rsp_uni_ff, rsp_uni_in;
   logic              rsp_sel_ff, rsp_sel_in;
   logic              rsp_sched_ff, rsp_sched_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              fixed_mode;
   logic              go_fixed;
   logic              go_prob;
   logic              launch;
   logic [UNI_W-1:0]  uni_masked;
   logic [CW-1:0]     n_eff;
   logic [MW-1:0]     product;
   logic [PW-1:0]     draw_idx;
   logic [CW-1:0]     top_full;
   logic [PW-1:0]     step_pred;
   logic [PW-1:0]     top_val;
   logic              step_sel;
   logic              step_sched;
   logic              step_last;
   logic [CMP_W-1:0]  cmp_lhs;
   logic [CMP_W-1:0]  cmp_rhs;
   logic [CFG_W-1:0]  accepted_inc;
   logic [CW-1:0]     visit_inc;

   perm_req_type      perm_req;
   prob_req_type      prob_req;
   logic [PRED_W-1:0] perm_rd_a;
   logic [PRED_W-1:0] perm_rd_b;
   logic [PROB_W-1:0] prob_rd;

   scps_perm_mem #(
      .DEPTH(MAX_PRED)
   ) u_perm_mem (
      .clock    (clock),
      .req      (perm_req),
      .rd_data_a(perm_rd_a),
      .rd_data_b(perm_rd_b)
   );

   scps_prob_mem #(
      .DEPTH(MAX_PRED)
   ) u_prob_mem (
      .clock  (clock),
      .reset  (reset),
      .req    (prob_req),
      .rd_data(prob_rd)
   );

   // request decode
   assign accept     = start && (state_ff == ST_IDLE);
   assign fixed_mode = (fixed_count_ff != '0);
   assign go_fixed   = fixed_mode && (remaining_ff != '0);
   assign go_prob    = !fixed_mode && (visit_ff < size_ff);
   assign launch     = accept && (req_type == REQ_UNIFORM) && active_ff
                       && (go_fixed || go_prob);
   assign uni_masked = req_uniform & UNI_MASK;
   assign n_eff      = (pred_count_ff > CFG_W'(MAX_PRED)) ? CW'(MAX_PRED)
                                                         : CW'(pred_count_ff);
   assign product    = MW'(remaining_ff) * MW'(uni_masked);
   assign draw_idx   = PW'(product >> UNIFORM_BITS);
   assign top_full   = remaining_ff - CW'(1);

   // step datapath
   assign top_val      = written_ff[top_ff] ? perm_rd_b[PW-1:0] : top_ff;
   assign cmp_lhs      = CMP_W'({uni_ff, {PROB_FRAC_BITS{1'b0}}});
   assign cmp_rhs      = {prob_rd, {UNIFORM_BITS{1'b0}}};
   assign accepted_inc = accepted_ff + CFG_W'(1);
   assign visit_inc    = visit_ff + CW'(1);

   always_comb begin
      if (fixed_step_ff) begin
         step_pred  = written_ff[idx_ff] ? perm_rd_a[PW-1:0] : idx_ff;
         step_sel   = 1'b1;
         step_sched = mask_ff[step_pred];
         step_last  = (step_sched && (accepted_inc == fixed_count_ff))
                      || (remaining_ff == CW'(1));
      end else begin
         step_pred  = visit_ff[PW-1:0];
         step_sel   = (cmp_lhs < cmp_rhs);
         step_sched = step_sel && mask_ff[step_pred];
         step_last  = (visit_inc >= size_ff);
      end
   end

   // memory requests
   always_comb begin
      perm_req.rd_en     = launch && fixed_mode;
      perm_req.rd_addr_a = PRED_W'(draw_idx);
      perm_req.rd_addr_b = PRED_W'(top_full[PW-1:0]);
      perm_req.wr_en     = (state_ff == ST_STEP) && fixed_step_ff;
      perm_req.wr_addr   = PRED_W'(idx_ff);
      perm_req.wr_data   = PRED_W'(top_val);

      prob_req.rd_en     = launch && !fixed_mode;
      prob_req.rd_addr   = PRED_W'(visit_ff[PW-1:0]);
      prob_req.wr_en     = accept && (req_type == REQ_LOAD)
                           && ({1'b0, req_prob_index} < (PRED_W + 1)'(MAX_PRED));
      prob_req.wr_addr   = req_prob_index;
      prob_req.wr_data   = req_prob_value;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (launch) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy            = (state_ff == ST_STEP);
      rsp_valid       = rsp_valid_ff;
      rsp_out_node    = rsp_node_ff;
      rsp_predictor   = rsp_pred_ff;
      rsp_out_uniform = rsp_uni_ff;
      rsp_selected    = rsp_sel_ff;
      rsp_scheduled   = rsp_sched_ff;
      rsp_last        = rsp_last_ff;
   end

   // register updates
   always_comb begin
      fixed_count_in = fixed_count_ff;
      pred_count_in  = pred_count_ff;
      node_in        = node_ff;
      mask_in        = mask_ff;
      written_in     = written_ff;
      active_in      = active_ff;
      size_in        = size_ff;
      remaining_in   = remaining_ff;
      accepted_in    = accepted_ff;
      visit_in       = visit_ff;
      fixed_step_in  = fixed_step_ff;
      idx_in         = idx_ff;
      top_in         = top_ff;
      uni_in         = uni_ff;
      rsp_valid_in   = 1'b0;
      rsp_node_in    = rsp_node_ff;
      rsp_pred_in    = rsp_pred_ff;
      rsp_uni_in     = rsp_uni_ff;
      rsp_sel_in     = rsp_sel_ff;
      rsp_sched_in   = rsp_sched_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_FIXED_COUNT: fixed_count_in = csr_wdata;
            CSR_PRED_COUNT:  pred_count_in  = csr_wdata;
            default: begin
            end
         endcase
      end

      if (accept) begin
         case (req_type)
            REQ_START: begin
               node_in      = req_node_index;
               mask_in      = req_eligible_mask;
               written_in   = '0;
               size_in      = n_eff;
               remaining_in = n_eff;
               accepted_in  = '0;
               visit_in     = '0;
               active_in    = !req_unsplitable && (n_eff != '0);
            end
            REQ_UNIFORM: begin
               if (launch) begin
                  fixed_step_in = fixed_mode;
                  idx_in        = draw_idx;
                  top_in        = top_full[PW-1:0];
                  uni_in        = uni_masked;
               end else begin
                  // drop: node not active, pool exhausted or walk finished
                  active_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      if (state_ff == ST_STEP) begin
         if (fixed_step_ff) begin
            written_in[idx_ff] = 1'b1;
            remaining_in       = top_full;
            if (step_sched) begin
               accepted_in = accepted_inc;
            end
         end else begin
            visit_in = visit_inc;
         end
         if (step_last) begin
            active_in = 1'b0;
         end
         rsp_valid_in = 1'b1;
         rsp_node_in  = node_ff;
         rsp_pred_in  = PRED_W'(step_pred);
         rsp_uni_in   = uni_ff;
         rsp_sel_in   = step_sel;
         rsp_sched_in = step_sched;
         rsp_last_in  = step_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fixed_count_ff <= FIXED_COUNT_RST;
         pred_count_ff  <= PRED_COUNT_RST;
         node_ff        <= '0;
         mask_ff        <= '0;
         written_ff     <= '0;
         active_ff      <= 1'b0;
         size_ff        <= '0;
         remaining_ff   <= '0;
         accepted_ff    <= '0;
         visit_ff       <= '0;
         fixed_step_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fixed_count_ff <= fixed_count_in;
         pred_count_ff  <= pred_count_in;
         node_ff        <= node_in;
         mask_ff        <= mask_in;
         written_ff     <= written_in;
         active_ff      <= active_in;
         size_ff        <= size_in;
         remaining_ff   <= remaining_in;
         accepted_ff    <= accepted_in;
         visit_ff       <= visit_in;
         fixed_step_ff  <= fixed_step_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      top_ff       <= top_in;
      uni_ff       <= uni_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_pred_ff  <= rsp_pred_in;
      rsp_uni_ff   <= rsp_uni_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_sched_ff <= rsp_sched_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef ASSERT_OFF
   a_rsp_after_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_STEP))
      else $error("result without a preceding step");

   a_step_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |=> (state_ff == ST_IDLE))
      else $error("step lasted more than one cycle");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !active_ff)
      else $error("node still open after last result");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      remaining_ff <= size_ff)
      else $error("pool count exceeds node size");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the split candidate predictor sampler. A queue of
// node, uniform and probability-load transactions feeds a falling-edge
// driver. A rising-edge monitor tracks the accepted transactions with its
// own copy of the draw and walk state, and checks every candidate on the
// rsp_ ports against the oldest predicted one. Directed cases come first,
// then random node walks across a range of fixed_count and pred_count values.
// ----------------------------------------------------------------------------
module tb_top;
   import scps_pkg::*;

   localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PHASES = 12;

   typedef struct {
      logic [REQ_W-1:0]  kind;
      logic [NODE_W-1:0] node;
      logic              unsplit;
      logic [63:0]       mask;
      logic [UNI_W-1:0]  uni;
      logic [PRED_W-1:0] pidx;
      logic [PROB_W-1:0] pval;
      int unsigned       gap;
      logic              hold;
   } item_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [PRED_W-1:0] pred;
      logic [UNI_W-1:0]  uni;
      logic              sel;
      logic              sched;
      logic              is_last;
   } cand_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [REQ_W-1:0]     req_type = '0;
   logic [NODE_W-1:0]    req_node_index = '0;
   logic                 req_unsplitable = 1'b0;
   logic [63:0]          req_eligible_mask = '0;
   logic [UNI_W-1:0]     req_uniform = '0;
   logic [PRED_W-1:0]    req_prob_index = '0;
   logic [PROB_W-1:0]    req_prob_value = '0;
   logic                 rsp_valid;
   logic [NODE_W-1:0]    rsp_out_node;
   logic [PRED_W-1:0]    rsp_predictor;
   logic [UNI_W-1:0]     rsp_out_uniform;
   logic                 rsp_selected;
   logic                 rsp_scheduled;
   logic                 rsp_last;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   item_type item_q[$];
   cand_type cand_q[$];
   int unsigned fail_count = 0;
   int unsigned issued = 0;
   int unsigned gap_left = 0;
   logic in_flight = 1'b0;
   logic req_fired = 1'b0;
   logic no_idle = 1'b0;

   // sampler state as seen from outside
   logic [PRED_W-1:0] perm_tab[MAX_PRED_DEF];
   logic [63:0]       perm_set;
   logic [PROB_W-1:0] prob_tab[MAX_PRED_DEF];
   int unsigned       pool_left, hits, visit_ptr, node_span;
   logic [NODE_W-1:0] node_id;
   logic [63:0]       node_accept;
   logic              node_open;
   logic [CFG_W-1:0]  fixed_count_m, pred_count_m;

   split_candidate_predictor_sampler u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_node_index(req_node_index),
      .req_unsplitable(req_unsplitable),
      .req_eligible_mask(req_eligible_mask),
      .req_uniform(req_uniform),
      .req_prob_index(req_prob_index),
      .req_prob_value(req_prob_value),
      .rsp_valid(rsp_valid),
      .rsp_out_node(rsp_out_node),
      .rsp_predictor(rsp_predictor),
      .rsp_out_uniform(rsp_out_uniform),
      .rsp_selected(rsp_selected),
      .rsp_scheduled(rsp_scheduled),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [PRED_W-1:0] perm_rd(input int unsigned i);
      return perm_set[i] ? perm_tab[i] : PRED_W'(i);
   endfunction

   task automatic clear_sampler();
      for (int i = 0; i < MAX_PRED_DEF; i++) begin
         perm_tab[i] = '0;
         prob_tab[i] = '0;
      end
      perm_set = '0;
      pool_left = 0;
      hits = 0;
      visit_ptr = 0;
      node_span = 0;
      node_id = '0;
      node_accept = '0;
      node_open = 1'b0;
      fixed_count_m = FIXED_COUNT_RST;
      pred_count_m = PRED_COUNT_RST;
   endtask

   task automatic draw_candidate(input item_type it);
      int unsigned n, idx, top;
      logic [PRED_W-1:0] pick;
      cand_type c;
      logic emit;
      n = (pred_count_m < MAX_PRED_DEF) ? pred_count_m : MAX_PRED_DEF;
      emit = 1'b0;
      c = '0;
      case (it.kind)
         REQ_START: begin
            node_id = it.node;
            node_accept = it.mask;
            perm_set = '0;
            pool_left = n;
            node_span = n;
            hits = 0;
            visit_ptr = 0;
            node_open = !it.unsplit && n != 0;
         end
         REQ_LOAD: prob_tab[it.pidx] = it.pval;
         REQ_UNIFORM: begin
            if (node_open && fixed_count_m != 0) begin
               if (pool_left == 0) begin
                  node_open = 1'b0;
               end else begin
                  idx = (pool_left * int'(it.uni)) >> UNIFORM_BITS;
                  if (idx >= pool_left) idx = pool_left - 1;
                  top = pool_left - 1;
                  pick = perm_rd(idx);
                  perm_tab[idx] = perm_rd(top);
                  perm_set[idx] = 1'b1;
                  pool_left--;
                  c.sel = 1'b1;
                  c.sched = node_accept[pick];
                  if (c.sched) hits = (hits + 1) & 32'h7F;
                  c.is_last = (c.sched && hits == fixed_count_m) || pool_left == 0;
                  c.pred = pick;
                  emit = 1'b1;
               end
            end else if (node_open) begin
               if (visit_ptr >= node_span) begin
                  node_open = 1'b0;
               end else begin
                  c.pred = PRED_W'(visit_ptr);
                  c.sel = {1'b0, it.uni} < prob_tab[visit_ptr];
                  c.sched = c.sel & node_accept[visit_ptr];
                  visit_ptr++;
                  c.is_last = visit_ptr >= node_span;
                  emit = 1'b1;
               end
            end
         end
         default: ;
      endcase
      if (emit) begin
         if (c.is_last) node_open = 1'b0;
         c.node = node_id;
         c.uni = it.uni;
         cand_q.insert(cand_q.size(), c);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      item_type it;
      cand_type want;
      req_fired = 1'b0;
      if (reset) begin
         clear_sampler();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIXED_COUNT: fixed_count_m = csr_wdata;
               CSR_PRED_COUNT:  pred_count_m = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid !== 1'b0) begin
            if (cand_q.size() == 0) begin
               fail_count++;
               $error("unexpected candidate: node %0h predictor %0d uniform %0h",
                      rsp_out_node, rsp_predictor, rsp_out_uniform);
            end else begin
               want = cand_q.pop_front();
               check_field("out_node", want.node, rsp_out_node);
               check_field("predictor", want.pred, rsp_predictor);
               check_field("out_uniform", want.uni, rsp_out_uniform);
               check_field("selected", want.sel, rsp_selected);
               check_field("scheduled", want.sched, rsp_scheduled);
               check_field("last", want.is_last, rsp_last);
            end
         end
         if (start && !busy) begin
            req_fired = 1'b1;
            it.kind = req_type;
            it.node = req_node_index;
            it.unsplit = req_unsplitable;
            it.mask = req_eligible_mask;
            it.uni = req_uniform;
            it.pidx = req_prob_index;
            it.pval = req_prob_value;
            it.gap = 0;
            it.hold = 1'b0;
            draw_candidate(it);
         end
      end
   end

   always @(negedge clock) begin : driver
      item_type it;
      logic nxt_start;
      nxt_start = start;
      if (reset) begin
         nxt_start = 1'b0;
         in_flight = 1'b0;
         gap_left = 0;
      end else begin
         if (in_flight && req_fired) begin
            in_flight = 1'b0;
         end
         if (!in_flight) begin
            nxt_start = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (item_q.size() != 0 && (!item_q[0].hold || cand_q.size() == 0)) begin
               it = item_q.pop_front();
               req_type <= it.kind;
               req_node_index <= it.node;
               req_unsplitable <= it.unsplit;
               req_eligible_mask <= it.mask;
               req_uniform <= it.uni;
               req_prob_index <= it.pidx;
               req_prob_value <= it.pval;
               nxt_start = 1'b1;
               in_flight = 1'b1;
               gap_left = it.gap;
            end
         end
      end
      start <= nxt_start;
   end

   // start: a = mask, b = {unsplit, node}; uniform: b = uniform;
   // load: a = index, b = value
   task automatic send(input logic [REQ_W-1:0] kind, input logic [63:0] a,
                       input logic [PROB_W-1:0] b);
      item_type it;
      it.kind = kind;
      it.node = NODE_W'($urandom);
      it.unsplit = 1'($urandom);
      it.mask = {$urandom, $urandom};
      it.uni = UNI_W'($urandom);
      it.pidx = PRED_W'($urandom);
      it.pval = PROB_W'($urandom);
      case (kind)
         REQ_START: begin
            it.mask = a;
            it.node = b[NODE_W-1:0];
            it.unsplit = b[NODE_W];
         end
         REQ_UNIFORM: it.uni = b[UNI_W-1:0];
         REQ_LOAD: begin
            it.pidx = a[PRED_W-1:0];
            it.pval = b;
         end
         default: ;
      endcase
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      it.gap = no_idle ? 0 : $urandom_range(0, 17);
      it.hold = ($urandom_range(0, 59) == 0);
      item_q.insert(item_q.size(), it);
      issued++;
   endtask

   task automatic set_config(input logic [CFG_W-1:0] fixed, input logic [CFG_W-1:0] preds);
      while (item_q.size() != 0 || in_flight || cand_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_FIXED_COUNT;
      csr_wdata <= fixed;
      @(negedge clock);
      csr_index <= CSR_PRED_COUNT;
      csr_wdata <= preds;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input int unsigned budget);
      int unsigned base, span, len;
      logic [63:0] m;
      logic [UNI_W-1:0] u;
      logic [PROB_W-1:0] p;
      base = issued;
      span = (pred_count_m < MAX_PRED_DEF) ? pred_count_m : MAX_PRED_DEF;
      while (issued - base < budget) begin
         if ($urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 3))
               0: m = '1;
               1: m = '0;
               2: m = {$urandom, $urandom} & {$urandom, $urandom};
               default: m = {$urandom, $urandom};
            endcase
            send(REQ_START, m, {1'($urandom_range(0, 15) == 0), NODE_W'($urandom)});
            len = $urandom_range(1, span + 2);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  case ($urandom_range(0, 5))
                     0: p = '0;
                     1: p = 17'd65536;
                     2: p = '1;
                     3: p = PROB_W'($urandom_range(0, 65535));
                     default: p = PROB_W'($urandom);
                  endcase
                  send(REQ_LOAD, 64'($urandom_range(0, 63)), p);
               end
               case ($urandom_range(0, 7))
                  0: u = '0;
                  1: u = '1;
                  default: u = UNI_W'($urandom);
               endcase
               send(REQ_UNIFORM, '0, {1'b0, u});
            end
         end else begin
            send(REQ_W'($urandom_range(0, 3)), {$urandom, $urandom}, PROB_W'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] fixed_set[PHASES];
      logic [CFG_W-1:0] pred_set[PHASES];
      int k;
      fixed_set = '{7'd0, 7'd2, 7'd64, 7'd1, 7'd127, 7'd0,
                    7'd5, 7'd0, 7'd10, 7'd0, 7'd64, 7'd33};
      pred_set  = '{7'd8, 7'd64, 7'd64, 7'd1, 7'd5, 7'd64,
                    7'd127, 7'd1, 7'd20, 7'd33, 7'd17, 7'd100};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // probability walk over four predictors
      set_config(7'd0, 7'd4);
      send(REQ_UNIFORM, '0, 17'd1234);
      send(REQ_SPARE, '0, '0);
      send(REQ_LOAD, 64'd0, 17'h1FFFF);
      send(REQ_LOAD, 64'd1, 17'd0);
      send(REQ_LOAD, 64'd2, 17'd65536);
      send(REQ_LOAD, 64'd63, 17'd12345);
      send(REQ_START, '1, {1'b0, 16'hFFFF});
      send(REQ_UNIFORM, '0, 17'hFFFF);
      send(REQ_UNIFORM, '0, 17'd0);
      send(REQ_LOAD, 64'd3, 17'd1);
      send(REQ_UNIFORM, '0, 17'd0);
      send(REQ_UNIFORM, '0, 17'd0);
      send(REQ_UNIFORM, '0, 17'hFFFF);
      send(REQ_START, '0, {1'b1, 16'h0000});
      send(REQ_UNIFORM, '0, 17'd5);
      send(REQ_START, '0, {1'b0, 16'h0005});
      send(REQ_UNIFORM, '0, 17'h8000);
      send(REQ_START, 64'h8000_0000_0000_0001, {1'b0, 16'h0006});
      send(REQ_UNIFORM, '0, 17'd0);

      // fixed count above the pool size: ends on the empty pool
      set_config(7'd7, 7'd3);
      send(REQ_START, '1, {1'b0, 16'h1234});
      send(REQ_UNIFORM, '0, 17'hFFFF);
      send(REQ_UNIFORM, '0, 17'd0);
      send(REQ_UNIFORM, '0, 17'h8000);

      // no predictors in use: node closes at once
      set_config(7'd3, 7'd0);
      send(REQ_START, '1, {1'b0, 16'h0007});
      send(REQ_UNIFORM, '0, 17'd0);

      for (int i = 0; i < PHASES; i++) begin
         set_config(fixed_set[i], pred_set[i]);
         random_phase(100);
      end

      while (item_q.size() != 0 || in_flight) @(posedge clock);
      for (k = 0; k < 200 && cand_q.size() != 0; k++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (cand_q.size() != 0) begin
         fail_count++;
         $error("%0d expected candidates never arrived", cand_q.size());
      end
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
